// ===== hw/rtl/pksa_pkg.sv =====
`default_nettype none
package pksa_pkg;

  localparam int unsigned NUM_SETS_DEF        = 8;
  localparam int unsigned KEYS_PER_SET_DEF    = 8;
  localparam int unsigned QUERY_UNION_MAX_DEF = 8;
  localparam int unsigned MAX_QUERY_KEYS_DEF  = 8;

  localparam logic [31:0] FIRST_HANDLE = 32'd3000;
  localparam logic [6:0]  READ_LIMIT   = 7'd64;
  localparam logic [6:0]  COUNT_SAT    = 7'd127;

  typedef enum logic [2:0] {
    FN_CREATE      = 3'd0,
    FN_REMOVE      = 3'd1,
    FN_WRITE_KEY   = 3'd2,
    FN_SET_HEADER  = 3'd3,
    FN_LOAD_QUERY  = 3'd4,
    FN_QUERY       = 3'd5,
    FN_READ_UNION  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_NO_RESOURCES = 2'd2,
    ST_TOO_SMALL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_CREATE = 2'd1,
    DIR_REMOVE = 2'd2,
    DIR_HEADER = 2'd3
  } dir_op_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] handle;
    logic [3:0]  capacity;
    logic [2:0]  key_pos;
    logic [15:0] key;
    logic [15:0] modifiers;
    logic [3:0]  key_count;
    logic        exact;
    logic [6:0]  caller_capacity;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_handle;
    logic [6:0]  union_count;
    logic [15:0] union_modifiers;
    logic [15:0] union_key;
    logic        last;
  } result_t;

  typedef struct packed {
    dir_op_e     op;
    logic [3:0]  capacity;
    logic [3:0]  key_count;
    logic [15:0] modifiers;
  } dir_cmd_t;

  typedef struct packed {
    logic        full;
    logic        found;
    logic [3:0]  capacity;
    logic [31:0] next_handle;
  } dir_info_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pksa_mem.sv =====
`default_nettype none
module pksa_mem #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pksa_dir.sv =====
`default_nettype none
module pksa_dir #(
  parameter int unsigned NUM_SETS = pksa_pkg::NUM_SETS_DEF,
  localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  pksa_pkg::dir_cmd_t  cmd,
  input  logic [31:0]         handle,
  input  logic [SW-1:0]       gidx,
  output pksa_pkg::dir_info_t info,
  output logic [SW-1:0]       find_phys,
  output logic [SW-1:0]       free_phys,
  output logic [SW-1:0]       g_phys,
  output logic [SW:0]         live_count,
  output logic [3:0]          g_count,
  output logic [15:0]         g_modifiers
);
  import pksa_pkg::*;

  logic [NUM_SETS-1:0] used;
  logic [31:0]         next_handle;
  logic [31:0]         slot_handle [NUM_SETS];
  logic [3:0]          slot_capacity [NUM_SETS];
  logic [3:0]          slot_count [NUM_SETS];
  logic [15:0]         slot_modifiers [NUM_SETS];
  logic [SW-1:0]       order [NUM_SETS];
  logic [NUM_SETS-1:0] hit;
  logic [SW-1:0]       hit_pos;

  always_comb begin
    hit_pos   = '0;
    free_phys = '0;
    for (int i = 0; i < NUM_SETS; i++) begin
      hit[i] = ((SW+1)'(i) < live_count) && (slot_handle[order[i]] == handle);
    end
    for (int i = NUM_SETS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_pos = SW'(i);
      end
      if (!used[i]) begin
        free_phys = SW'(i);
      end
    end
  end

  assign find_phys        = order[hit_pos];
  assign info.found       = |hit;
  assign info.full        = (live_count == (SW+1)'(NUM_SETS));
  assign info.capacity    = slot_capacity[find_phys];
  assign info.next_handle = next_handle;
  assign g_phys           = order[gidx];
  assign g_count          = slot_count[g_phys];
  assign g_modifiers      = slot_modifiers[g_phys];

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      live_count  <= '0;
      next_handle <= FIRST_HANDLE;
    end else begin
      unique case (cmd.op)
        DIR_CREATE: begin
          used[free_phys] <= 1'b1;
          live_count      <= live_count + 1'b1;
          next_handle     <= next_handle + 32'd1;
        end
        DIR_REMOVE: begin
          used[find_phys] <= 1'b0;
          live_count      <= live_count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DIR_CREATE: begin
        order[live_count[SW-1:0]]  <= free_phys;
        slot_handle[free_phys]     <= next_handle;
        slot_capacity[free_phys]   <= cmd.capacity;
        slot_count[free_phys]      <= 4'd0;
        slot_modifiers[free_phys]  <= 16'd0;
      end
      DIR_REMOVE: begin
        for (int j = 0; j < NUM_SETS - 1; j++) begin
          if (SW'(j) >= hit_pos) begin
            order[j] <= order[j+1];
          end
        end
      end
      DIR_HEADER: begin
        slot_count[find_phys]     <= cmd.key_count;
        slot_modifiers[find_phys] <= cmd.modifiers;
      end
      default: begin
      end
    endcase
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_count) <= NUM_SETS) else $error("live set count out of range");
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == 32'(live_count)) else $error("slot map disagrees with count");
  a_cmd_legal: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DIR_REMOVE |-> info.found) and (cmd.op == DIR_CREATE |-> !info.full))
    else $error("directory command on missing or full set");

endmodule
`default_nettype wire

// ===== hw/rtl/pressed_key_set_aggregator.sv =====
// Pressed-key set aggregator.
// One command word enters on item/item_valid/item_stall and produces result words
// on result/result_valid/result_stall. Every command gives one word with last set,
// except a successful read union of a non-empty union, which gives one word per union key.
// Only one command is in the block at a time; item_stall stays high until its
// final word has been loaded into the output register.
// Create, remove, write key, set header and load query key pass through S_EXEC and
// S_RESP; create also steps through S_CLR to zero the new key row.
// Query and read union first rebuild the union by walking every counted key of
// every live set through the key memory and scanning the union memory for a
// duplicate, over S_GSET, S_GKEY, S_GSCAN and S_GCMP. A query then scans query keys
// against the union in S_QIN and S_QCMP, and an exact query also scans the union
// against the query keys; read union emits its words through S_ERD and S_ELD.
// A stalled output register holds its word; the block waits for it to drain.
// Reset empties the directory and sets the next handle to 3000; key, union and
// query memories need no clearing.
`default_nettype none
module pressed_key_set_aggregator #(
  parameter int unsigned NUM_SETS        = pksa_pkg::NUM_SETS_DEF,
  parameter int unsigned KEYS_PER_SET    = pksa_pkg::KEYS_PER_SET_DEF,
  parameter int unsigned QUERY_UNION_MAX = pksa_pkg::QUERY_UNION_MAX_DEF,
  parameter int unsigned MAX_QUERY_KEYS  = pksa_pkg::MAX_QUERY_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pksa_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_stall,
  output pksa_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall
);
  import pksa_pkg::*;

  localparam int unsigned SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned KW  = (KEYS_PER_SET > 1) ? $clog2(KEYS_PER_SET) : 1;
  localparam int unsigned UD  = NUM_SETS * KEYS_PER_SET;
  localparam int unsigned UW  = (UD > 1) ? $clog2(UD) : 1;
  localparam int unsigned QW  = (MAX_QUERY_KEYS > 1) ? $clog2(MAX_QUERY_KEYS) : 1;
  localparam int unsigned NW  = $clog2(UD + 1);
  localparam int unsigned CW  = (NW > 7) ? NW : 7;
  localparam int unsigned KMD = 2 ** (SW + KW);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_EXEC  = 15'b000000000000010,
    S_CLR   = 15'b000000000000100,
    S_GSET  = 15'b000000000001000,
    S_GKEY  = 15'b000000000010000,
    S_GSCAN = 15'b000000000100000,
    S_GCMP  = 15'b000000001000000,
    S_QCHK  = 15'b000000010000000,
    S_QOUT  = 15'b000000100000000,
    S_QIN   = 15'b000001000000000,
    S_QCMP  = 15'b000010000000000,
    S_RCHK  = 15'b000100000000000,
    S_ERD   = 15'b001000000000000,
    S_ELD   = 15'b010000000000000,
    S_RESP  = 15'b100000000000000
  } state_t;

  state_t        state, state_next;
  item_t         cmd, cmd_next;
  logic [SW:0]   sidx, sidx_next;
  logic [3:0]    kidx, kidx_next;
  logic [NW-1:0] un, un_next;
  logic [CW-1:0] uj, uj_next;
  logic [CW-1:0] qi, qi_next;
  logic [CW-1:0] ei, ei_next;
  logic [15:0]   umods, umods_next;
  logic          phase_b, phase_b_next;
  status_e       rstatus, rstatus_next;
  logic [31:0]   rnew, rnew_next;
  logic [SW-1:0] cphys, cphys_next;
  logic [KW:0]   ci, ci_next;

  dir_cmd_t      dcmd;
  dir_info_t     info;
  logic [SW-1:0] find_phys, free_phys, g_phys;
  logic [SW:0]   live_count;
  logic [3:0]    g_count;
  logic [15:0]   g_modifiers;

  logic                key_we, key_re;
  logic [SW+KW-1:0]    key_waddr, key_raddr;
  logic [15:0]         key_wdata, key_rdata;
  logic                un_we, un_re;
  logic [UW-1:0]       un_waddr, un_raddr;
  logic [15:0]         un_rdata;
  logic                q_we, q_re;
  logic [QW-1:0]       q_waddr, q_raddr;
  logic [15:0]         q_rdata;

  logic                out_free, out_load;
  result_t             out_next;
  logic [CW-1:0]       unx;
  logic [6:0]          ucount_sat;
  logic                show_union;
  logic [KW+2:0]       pos_k;
  logic [KW+3:0]       kidx_k;
  logic [QW+2:0]       pos_q;
  logic [6:0]          ccap;
  logic [CW-1:0]       inner_bound;

  pksa_dir #(.NUM_SETS(NUM_SETS)) u_dir (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dcmd),
    .handle      (cmd.handle),
    .gidx        (sidx[SW-1:0]),
    .info        (info),
    .find_phys   (find_phys),
    .free_phys   (free_phys),
    .g_phys      (g_phys),
    .live_count  (live_count),
    .g_count     (g_count),
    .g_modifiers (g_modifiers)
  );

  pksa_mem #(.WIDTH(16), .DEPTH(KMD)) u_key_mem (
    .clk (clk), .we (key_we), .waddr (key_waddr), .wdata (key_wdata),
    .re (key_re), .raddr (key_raddr), .rdata (key_rdata)
  );

  pksa_mem #(.WIDTH(16), .DEPTH(UD)) u_union_mem (
    .clk (clk), .we (un_we), .waddr (un_waddr), .wdata (key_rdata),
    .re (un_re), .raddr (un_raddr), .rdata (un_rdata)
  );

  pksa_mem #(.WIDTH(16), .DEPTH(MAX_QUERY_KEYS)) u_query_mem (
    .clk (clk), .we (q_we), .waddr (q_waddr), .wdata (cmd.key),
    .re (q_re), .raddr (q_raddr), .rdata (q_rdata)
  );

  assign item_stall  = (state != S_IDLE);
  assign out_free    = !result_valid || !result_stall;
  assign unx         = CW'(un);
  assign ucount_sat  = (unx > CW'(COUNT_SAT)) ? COUNT_SAT : unx[6:0];
  assign show_union  = (cmd.func == FN_QUERY) || (cmd.func == FN_READ_UNION);
  assign pos_k       = {KW'(0), cmd.key_pos};
  assign kidx_k      = {KW'(0), kidx};
  assign pos_q       = {QW'(0), cmd.key_pos};
  assign ccap        = (cmd.caller_capacity > READ_LIMIT) ? READ_LIMIT : cmd.caller_capacity;
  assign inner_bound = phase_b ? CW'(cmd.key_count) : unx;

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    sidx_next    = sidx;
    kidx_next    = kidx;
    un_next      = un;
    uj_next      = uj;
    qi_next      = qi;
    ei_next      = ei;
    umods_next   = umods;
    phase_b_next = phase_b;
    rstatus_next = rstatus;
    rnew_next    = rnew;
    cphys_next   = cphys;
    ci_next      = ci;

    dcmd.op        = DIR_NONE;
    dcmd.capacity  = cmd.capacity;
    dcmd.key_count = cmd.key_count;
    dcmd.modifiers = cmd.modifiers;

    key_we    = 1'b0;
    key_waddr = {find_phys, pos_k[KW-1:0]};
    key_wdata = cmd.key;
    key_re    = 1'b0;
    key_raddr = {g_phys, kidx_k[KW-1:0]};
    un_we     = 1'b0;
    un_waddr  = un[UW-1:0];
    un_re     = 1'b0;
    un_raddr  = uj[UW-1:0];
    q_we      = 1'b0;
    q_waddr   = pos_q[QW-1:0];
    q_re      = 1'b0;
    q_raddr   = qi[QW-1:0];

    out_load = 1'b0;
    out_next.status          = rstatus;
    out_next.new_handle      = rnew;
    out_next.union_count     = show_union ? ucount_sat : 7'd0;
    out_next.union_modifiers = show_union ? umods : 16'd0;
    out_next.union_key       = 16'd0;
    out_next.last            = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd_next     = item;
          sidx_next    = '0;
          un_next      = '0;
          umods_next   = '0;
          rnew_next    = '0;
          rstatus_next = ST_OK;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        unique case (func_e'(cmd.func))
          FN_CREATE: begin
            if (info.full || 32'(cmd.capacity) > KEYS_PER_SET) begin
              rstatus_next = ST_NO_RESOURCES;
            end else begin
              dcmd.op    = DIR_CREATE;
              rnew_next  = info.next_handle;
              cphys_next = free_phys;
              ci_next    = '0;
              state_next = S_CLR;
            end
          end
          FN_REMOVE: begin
            if (info.found) begin
              dcmd.op = DIR_REMOVE;
            end else begin
              rstatus_next = ST_NOT_FOUND;
            end
          end
          FN_WRITE_KEY: begin
            if (!info.found) begin
              rstatus_next = ST_NOT_FOUND;
            end else if ({1'b0, cmd.key_pos} >= info.capacity
                         || 32'(cmd.key_pos) >= KEYS_PER_SET) begin
              rstatus_next = ST_NO_RESOURCES;
            end else begin
              key_we = 1'b1;
            end
          end
          FN_SET_HEADER: begin
            if (!info.found) begin
              rstatus_next = ST_NOT_FOUND;
            end else if (cmd.key_count > info.capacity) begin
              rstatus_next = ST_NO_RESOURCES;
            end else begin
              dcmd.op = DIR_HEADER;
            end
          end
          FN_LOAD_QUERY: begin
            if (32'(cmd.key_pos) >= MAX_QUERY_KEYS) begin
              rstatus_next = ST_NO_RESOURCES;
            end else begin
              q_we = 1'b1;
            end
          end
          FN_QUERY, FN_READ_UNION: begin
            state_next = S_GSET;
          end
          default: begin
            rstatus_next = ST_NOT_FOUND;
          end
        endcase
      end
      S_CLR: begin
        key_we    = 1'b1;
        key_waddr = {cphys, ci[KW-1:0]};
        key_wdata = 16'd0;
        if (ci == (KW+1)'(KEYS_PER_SET - 1)) begin
          state_next = S_RESP;
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      S_GSET: begin
        if (sidx == live_count) begin
          state_next = (cmd.func == FN_QUERY) ? S_QCHK : S_RCHK;
        end else begin
          umods_next = umods | g_modifiers;
          kidx_next  = '0;
          state_next = S_GKEY;
        end
      end
      S_GKEY: begin
        if (kidx == g_count) begin
          sidx_next  = sidx + 1'b1;
          state_next = S_GSET;
        end else begin
          key_re     = 1'b1;
          uj_next    = '0;
          state_next = S_GSCAN;
        end
      end
      S_GSCAN: begin
        if (uj == unx) begin
          un_we      = 1'b1;
          un_next    = un + 1'b1;
          kidx_next  = kidx + 1'b1;
          state_next = S_GKEY;
        end else begin
          un_re      = 1'b1;
          state_next = S_GCMP;
        end
      end
      S_GCMP: begin
        if (un_rdata == key_rdata) begin
          kidx_next  = kidx + 1'b1;
          state_next = S_GKEY;
        end else begin
          uj_next    = uj + 1'b1;
          state_next = S_GSCAN;
        end
      end
      S_QCHK: begin
        state_next   = S_RESP;
        qi_next      = '0;
        phase_b_next = 1'b0;
        if (cmd.key_count == 4'd0 || 32'(cmd.key_count) > MAX_QUERY_KEYS) begin
          rstatus_next = ST_NOT_FOUND;
        end else if (32'(un) > QUERY_UNION_MAX) begin
          rstatus_next = ST_TOO_SMALL;
        end else if (cmd.exact && (umods != cmd.modifiers || unx != CW'(cmd.key_count))) begin
          rstatus_next = ST_NOT_FOUND;
        end else if (!cmd.exact && (umods & cmd.modifiers) != cmd.modifiers) begin
          rstatus_next = ST_NOT_FOUND;
        end else begin
          state_next = S_QOUT;
        end
      end
      S_QOUT: begin
        if (qi == CW'(cmd.key_count)) begin
          if (cmd.exact && !phase_b) begin
            phase_b_next = 1'b1;
            qi_next      = '0;
          end else begin
            state_next = S_RESP;
          end
        end else begin
          if (phase_b) begin
            un_re    = 1'b1;
            un_raddr = qi[UW-1:0];
          end else begin
            q_re = 1'b1;
          end
          uj_next    = '0;
          state_next = S_QIN;
        end
      end
      S_QIN: begin
        if (uj == inner_bound) begin
          rstatus_next = ST_NOT_FOUND;
          state_next   = S_RESP;
        end else begin
          if (phase_b) begin
            q_re    = 1'b1;
            q_raddr = uj[QW-1:0];
          end else begin
            un_re = 1'b1;
          end
          state_next = S_QCMP;
        end
      end
      S_QCMP: begin
        if (un_rdata == q_rdata) begin
          qi_next    = qi + 1'b1;
          state_next = S_QOUT;
        end else begin
          uj_next    = uj + 1'b1;
          state_next = S_QIN;
        end
      end
      S_RCHK: begin
        ei_next = '0;
        if (unx > CW'(ccap)) begin
          rstatus_next = ST_TOO_SMALL;
          state_next   = S_RESP;
        end else if (un == '0) begin
          state_next = S_RESP;
        end else begin
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        un_re      = 1'b1;
        un_raddr   = ei[UW-1:0];
        state_next = S_ELD;
      end
      S_ELD: begin
        out_next.status     = ST_OK;
        out_next.new_handle = 32'd0;
        out_next.union_key  = un_rdata;
        out_next.last       = (ei == unx - 1'b1);
        if (out_free) begin
          out_load = 1'b1;
          if (ei == unx - 1'b1) begin
            state_next = S_IDLE;
          end else begin
            ei_next    = ei + 1'b1;
            state_next = S_ERD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    sidx    <= sidx_next;
    kidx    <= kidx_next;
    un      <= un_next;
    uj      <= uj_next;
    qi      <= qi_next;
    ei      <= ei_next;
    umods   <= umods_next;
    phase_b <= phase_b_next;
    rstatus <= rstatus_next;
    rnew    <= rnew_next;
    cphys   <= cphys_next;
    ci      <= ci_next;
    if (out_load) begin
      result <= out_next;
    end
  end

  a_union_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_GSCAN || state == S_GCMP || state == S_GKEY) |-> 32'(un) <= UD)
    else $error("union count beyond union memory");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == S_EXEC)
    else $error("accepted word not executed");
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERD || state == S_ELD) |-> (un != '0 && ei < unx))
    else $error("union read beyond gathered keys");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import pksa_pkg::*;

  localparam int unsigned SETS = NUM_SETS_DEF;
  localparam int unsigned KPS = KEYS_PER_SET_DEF;
  localparam int unsigned QMAX = QUERY_UNION_MAX_DEF;
  localparam int unsigned QKEYS = MAX_QUERY_KEYS_DEF;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  item_t item = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  result_t result;
  logic result_valid;
  logic result_stall = 1'b0;

  pressed_key_set_aggregator dut (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid), .item_stall(item_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall)
  );

  always #2 clk = ~clk;

  // Predictor state: the live key sets, packed in creation order.
  logic        set_live [SETS];
  logic [31:0] set_handle [SETS];
  logic [3:0]  set_cap [SETS];
  logic [3:0]  set_count [SETS];
  logic [15:0] set_mods [SETS];
  logic [15:0] set_keys [SETS][KPS];
  logic [31:0] handle_next;
  logic [15:0] query_buf [QKEYS];
  logic [15:0] union_keys [$];
  logic [15:0] union_mods;

  result_t expected_words [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  logic [31:0] issued [$];

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    $display("mismatch on %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic result_t word(input status_e st, input logic [31:0] nh,
                                   input int unsigned uc, input logic [15:0] um,
                                   input logic [15:0] uk, input logic lst);
    result_t r;
    r.status = st;
    r.new_handle = nh;
    r.union_count = (uc > 127) ? COUNT_SAT : 7'(uc);
    r.union_modifiers = um;
    r.union_key = uk;
    r.last = lst;
    return r;
  endfunction

  function automatic int find_set(input logic [31:0] h);
    for (int i = 0; i < SETS; i++)
      if (set_live[i] && set_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic void gather_union();
    bit dup;
    union_keys.delete();
    union_mods = '0;
    for (int s = 0; s < SETS; s++) begin
      if (set_live[s]) begin
        union_mods |= set_mods[s];
        for (int i = 0; i < set_count[s] && i < KPS; i++) begin
          dup = 1'b0;
          foreach (union_keys[j]) if (union_keys[j] == set_keys[s][i]) dup = 1'b1;
          if (!dup) union_keys.push_back(set_keys[s][i]);
        end
      end
    end
  endfunction

  function automatic status_e query_status(input item_t it);
    logic [15:0] a [$];
    logic [15:0] b [$];
    bit hit;
    int unsigned n;
    n = union_keys.size();
    if (it.key_count == 0 || it.key_count > QKEYS) return ST_NOT_FOUND;
    if (n > QMAX) return ST_TOO_SMALL;
    if (it.exact) begin
      if (union_mods != it.modifiers || n != it.key_count) return ST_NOT_FOUND;
      for (int i = 0; i < it.key_count; i++) begin
        a.push_back(query_buf[i]);
        b.push_back(union_keys[i]);
      end
      a.sort();
      b.sort();
      return (a == b) ? ST_OK : ST_NOT_FOUND;
    end
    if ((union_mods & it.modifiers) != it.modifiers) return ST_NOT_FOUND;
    for (int i = 0; i < it.key_count; i++) begin
      hit = 1'b0;
      foreach (union_keys[j]) if (union_keys[j] == query_buf[i]) hit = 1'b1;
      if (!hit) return ST_NOT_FOUND;
    end
    return ST_OK;
  endfunction

  function automatic void predict_aggregator(input item_t it);
    int s;
    int unsigned n;
    int unsigned lim;
    case (it.func)
      FN_CREATE: begin
        n = 0;
        while (n < SETS && set_live[n]) n++;
        if (n >= SETS || it.capacity > KPS) begin
          expected_words.push_back(word(ST_NO_RESOURCES, 0, 0, 0, 0, 1'b1));
        end else begin
          set_live[n] = 1'b1;
          set_handle[n] = handle_next;
          set_cap[n] = it.capacity;
          set_count[n] = '0;
          set_mods[n] = '0;
          for (int k = 0; k < KPS; k++) set_keys[n][k] = '0;
          expected_words.push_back(word(ST_OK, handle_next, 0, 0, 0, 1'b1));
          handle_next = handle_next + 1;
        end
      end
      FN_REMOVE: begin
        s = find_set(it.handle);
        if (s < 0) begin
          expected_words.push_back(word(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1));
        end else begin
          for (int i = s; i + 1 < SETS; i++) begin
            set_live[i] = set_live[i + 1];
            set_handle[i] = set_handle[i + 1];
            set_cap[i] = set_cap[i + 1];
            set_count[i] = set_count[i + 1];
            set_mods[i] = set_mods[i + 1];
            for (int k = 0; k < KPS; k++) set_keys[i][k] = set_keys[i + 1][k];
          end
          set_live[SETS - 1] = 1'b0;
          expected_words.push_back(word(ST_OK, 0, 0, 0, 0, 1'b1));
        end
      end
      FN_WRITE_KEY: begin
        s = find_set(it.handle);
        if (s < 0) begin
          expected_words.push_back(word(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1));
        end else if (it.key_pos >= set_cap[s] || it.key_pos >= KPS) begin
          expected_words.push_back(word(ST_NO_RESOURCES, 0, 0, 0, 0, 1'b1));
        end else begin
          set_keys[s][it.key_pos] = it.key;
          expected_words.push_back(word(ST_OK, 0, 0, 0, 0, 1'b1));
        end
      end
      FN_SET_HEADER: begin
        s = find_set(it.handle);
        if (s < 0) begin
          expected_words.push_back(word(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1));
        end else if (it.key_count > set_cap[s]) begin
          expected_words.push_back(word(ST_NO_RESOURCES, 0, 0, 0, 0, 1'b1));
        end else begin
          set_count[s] = it.key_count;
          set_mods[s] = it.modifiers;
          expected_words.push_back(word(ST_OK, 0, 0, 0, 0, 1'b1));
        end
      end
      FN_LOAD_QUERY: begin
        if (it.key_pos >= QKEYS) begin
          expected_words.push_back(word(ST_NO_RESOURCES, 0, 0, 0, 0, 1'b1));
        end else begin
          query_buf[it.key_pos] = it.key;
          expected_words.push_back(word(ST_OK, 0, 0, 0, 0, 1'b1));
        end
      end
      FN_QUERY: begin
        gather_union();
        expected_words.push_back(word(query_status(it), 0, union_keys.size(), union_mods, 0,
                                      1'b1));
      end
      FN_READ_UNION: begin
        gather_union();
        n = union_keys.size();
        lim = (it.caller_capacity > READ_LIMIT) ? READ_LIMIT : it.caller_capacity;
        if (n > lim)
          expected_words.push_back(word(ST_TOO_SMALL, 0, n, union_mods, 0, 1'b1));
        else if (n == 0)
          expected_words.push_back(word(ST_OK, 0, 0, union_mods, 0, 1'b1));
        else
          for (int i = 0; i < n; i++)
            expected_words.push_back(word(ST_OK, 0, n, union_mods, union_keys[i],
                                          i + 1 == n));
      end
      default: expected_words.push_back(word(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1));
    endcase
  endfunction

  // Result side: random stalls, and the comparison against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid && !result_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", result, '0);
      end else begin
        if (result !== expected_words[0]) report_mismatch("result word", result,
                                                          expected_words[0]);
        void'(expected_words.pop_front());
      end
    end
    result_stall <= !quiet && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input item_t it);
    while (!quiet && $urandom_range(99) < 6) @(posedge clk);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_aggregator(it);
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t make_item(input func_e f, input logic [31:0] h,
                                      input logic [3:0] cap, input logic [2:0] pos,
                                      input logic [15:0] k, input logic [15:0] m,
                                      input logic [3:0] kc, input logic ex,
                                      input logic [6:0] cc);
    item_t it;
    it.func = f;
    it.handle = h;
    it.capacity = cap;
    it.key_pos = pos;
    it.key = k;
    it.modifiers = m;
    it.key_count = kc;
    it.exact = ex;
    it.caller_capacity = cc;
    return it;
  endfunction

  function automatic logic [31:0] pick_handle();
    if (issued.size() == 0 || $urandom_range(9) == 0) return $urandom();
    return issued[$urandom_range(issued.size() - 1)];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned r;
    it = item_t'($bits(item_t)'({$urandom(), $urandom(), $urandom()}));
    r = $urandom_range(99);
    if (r < 12) it.func = FN_CREATE;
    else if (r < 20) it.func = FN_REMOVE;
    else if (r < 42) it.func = FN_WRITE_KEY;
    else if (r < 56) it.func = FN_SET_HEADER;
    else if (r < 72) it.func = FN_LOAD_QUERY;
    else if (r < 86) it.func = FN_QUERY;
    else if (r < 98) it.func = FN_READ_UNION;
    else it.func = 3'd7;
    if (it.func != FN_CREATE && $urandom_range(9) != 0) it.handle = pick_handle();
    if ($urandom_range(7) != 0) it.capacity = $urandom_range(KPS);
    if ($urandom_range(7) != 0) it.key_count = $urandom_range(QKEYS);
    if ($urandom_range(3) != 0) it.key = $urandom_range(15);
    if ($urandom_range(3) != 0) it.modifiers = $urandom_range(15);
    if ($urandom_range(3) != 0) it.caller_capacity = $urandom_range(QMAX + 4);
    // A query may only read query keys that have been loaded.
    if (it.func == FN_QUERY && it.key_count > 0 && it.key_count <= QKEYS)
      for (int i = 0; i < it.key_count; i++) if (query_buf[i] === 'x) it.key_count = i;
    return it;
  endfunction

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  item_t directed [$];
  item_t it;

  initial begin
    for (int i = 0; i < SETS; i++) set_live[i] = 1'b0;
    for (int i = 0; i < QKEYS; i++) query_buf[i] = 'x;
    handle_next = FIRST_HANDLE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_item(FN_REMOVE, 32'd3000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_READ_UNION, 0, 0, 0, 0, 0, 0, 0, 7'd127));
    directed.push_back(make_item(FN_CREATE, 0, 4'd15, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_CREATE, 0, 4'd8, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_CREATE, 0, 4'd0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_WRITE_KEY, 32'd3000, 0, 3'd7, 16'hFFFF, 0, 0, 0, 0));
    directed.push_back(make_item(FN_WRITE_KEY, 32'd3000, 0, 3'd0, 16'h0000, 0, 0, 0, 0));
    directed.push_back(make_item(FN_WRITE_KEY, 32'd3001, 0, 3'd0, 16'h0004, 0, 0, 0, 0));
    directed.push_back(make_item(FN_WRITE_KEY, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_SET_HEADER, 32'd3000, 0, 0, 0, 16'hFFFF, 4'd8, 0, 0));
    directed.push_back(make_item(FN_SET_HEADER, 32'd3001, 0, 0, 0, 16'h0001, 4'd1, 0, 0));
    directed.push_back(make_item(FN_LOAD_QUERY, 0, 0, 3'd0, 16'hFFFF, 0, 0, 0, 0));
    directed.push_back(make_item(FN_LOAD_QUERY, 0, 0, 3'd1, 16'h0000, 0, 0, 0, 0));
    directed.push_back(make_item(FN_QUERY, 0, 0, 0, 0, 16'hFFFF, 4'd2, 1'b0, 0));
    directed.push_back(make_item(FN_QUERY, 0, 0, 0, 0, 16'hFFFF, 4'd2, 1'b1, 0));
    directed.push_back(make_item(FN_QUERY, 0, 0, 0, 0, 0, 4'd0, 1'b0, 0));
    directed.push_back(make_item(FN_QUERY, 0, 0, 0, 0, 0, 4'd15, 1'b1, 0));
    directed.push_back(make_item(FN_READ_UNION, 0, 0, 0, 0, 0, 0, 0, 7'd0));
    directed.push_back(make_item(FN_READ_UNION, 0, 0, 0, 0, 0, 0, 0, 7'd100));
    directed.push_back(make_item(func_e'(3'd7), 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_REMOVE, 32'd3000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(FN_READ_UNION, 0, 0, 0, 0, 0, 0, 0, 7'd64));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // Fill every slot, then overflow, then a quiet stretch without idling.
    for (int i = 0; i < SETS + 1; i++)
      send_word(make_item(FN_CREATE, 0, 4'($urandom_range(KPS)), 0, 0, 0, 0, 0, 0));
    issued.delete();
    for (logic [31:0] h = FIRST_HANDLE; h != handle_next; h++) issued.push_back(h);

    for (int n = 0; n < 230; n++) begin
      quiet = (n >= 100 && n < 150);
      it = random_item();
      send_word(it);
      if (it.func == FN_CREATE && expected_words[$].status == ST_OK)
        issued.push_back(expected_words[$].new_handle);
      if (n == 200) drain();
    end
    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
